// ===== hw/rtl/matrix4_column_multiply_top_macros.svh =====
// Assertion helpers used by matrix4_column_multiply_top.sv.
`ifndef MATRIX4_COLUMN_MULTIPLY_TOP_MACROS_SVH
`define MATRIX4_COLUMN_MULTIPLY_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MCM_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");
`define MCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define MCM_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define MCM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ===== hw/rtl/mcm_pkg.sv =====
`default_nettype none
package mcm_pkg;

  localparam int ELEM_W = 32;
  localparam int LINE_W = 2;
  localparam int LANES  = 4;
  localparam int PROD_W = 2 * ELEM_W;
  // four products summed exactly
  localparam int SUM_W  = PROD_W + 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MUL  = 1'b1;

  localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/matrix4_column_multiply_top.sv =====
// An accepted column item passes the product, sum and output registers in turn on its way to the output.
// Throughput: one item per cycle while the output is not stalled; row loads and column items may alternate freely.
// Each of the four row lanes has one 32x32 multiplier per column, registered,
// then a registered four-way sum; the output register merges the lanes.
// Reset (rst_ni, async, active low) clears the A store to zero and empties the pipe.
`default_nettype none
`include "matrix4_column_multiply_top_macros.svh"
module matrix4_column_multiply_top import mcm_pkg::*; #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     kind_i,
  input  wire logic [LINE_W-1:0]        line_index_i,
  input  wire logic signed [ELEM_W-1:0] elem_0_i,
  input  wire logic signed [ELEM_W-1:0] elem_1_i,
  input  wire logic signed [ELEM_W-1:0] elem_2_i,
  input  wire logic signed [ELEM_W-1:0] elem_3_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [LINE_W-1:0]             out_column_o,
  output logic signed [ELEM_W-1:0]      prod_0_o,
  output logic signed [ELEM_W-1:0]      prod_1_o,
  output logic signed [ELEM_W-1:0]      prod_2_o,
  output logic signed [ELEM_W-1:0]      prod_3_o,
  output logic                          saturated_o
);

  // rows and columns past the four lanes never reach an output
  localparam int NUSE = (DIM < LANES) ? DIM : LANES;

  logic signed [ELEM_W-1:0] col [LANES];
  logic signed [ELEM_W-1:0] a_q [NUSE][NUSE];
  logic signed [ELEM_W-1:0] lane_prod [LANES];
  logic [LANES-1:0]         lane_clip;
  pipe_ctrl_t               ctrl;

  logic                     accept;
  logic                     out_ready, s2_ready, s1_ready;
  logic                     s1_v_q, s2_v_q, out_v_q;
  logic [LINE_W-1:0]        col1_q, col2_q, out_col_q;
  logic signed [ELEM_W-1:0] prod_q [LANES];
  logic                     sat_q;

  assign col[0] = elem_0_i;
  assign col[1] = elem_1_i;
  assign col[2] = elem_2_i;
  assign col[3] = elem_3_i;

  assign out_ready  = ~out_v_q | ~out_stall_i;
  assign s2_ready   = ~s2_v_q | out_ready;
  assign s1_ready   = ~s1_v_q | s2_ready;
  assign in_stall_o = ~s1_ready;
  assign accept     = in_valid_i & s1_ready;

  assign ctrl.s1_en = s1_ready;
  assign ctrl.s2_en = s2_ready;

  // A store; a load to a row at or past DIM matches no row and is dropped
  for (genvar r = 0; r < NUSE; r++) begin : g_row
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < NUSE; k++) begin
          a_q[r][k] <= '0;
        end
      end else if (accept && kind_i == KIND_LOAD && line_index_i == LINE_W'(r)) begin
        for (int k = 0; k < NUSE; k++) begin
          a_q[r][k] <= col[k];
        end
      end
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < NUSE) begin : g_on
      mcm_lane #(
        .NCOL      (NUSE),
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .row_i  (a_q[j]),
        .col_i  (col),
        .prod_o (lane_prod[j]),
        .clip_o (lane_clip[j])
      );
    end else begin : g_off
      assign lane_prod[j] = '0;
      assign lane_clip[j] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= accept & (kind_i == KIND_MUL);
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      col1_q <= line_index_i;
    end
    if (s2_ready) begin
      col2_q <= col1_q;
    end
    if (out_ready) begin
      out_col_q <= col2_q;
      prod_q    <= lane_prod;
      sat_q     <= |lane_clip;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_column_o = out_col_q;
  assign prod_0_o     = prod_q[0];
  assign prod_1_o     = prod_q[1];
  assign prod_2_o     = prod_q[2];
  assign prod_3_o     = prod_q[3];
  assign saturated_o  = sat_q;

  `MCM_ASSERT_NEXT(a_mul_enters, clk_i, rst_ni, accept && kind_i == KIND_MUL, s1_v_q)
  `MCM_ASSERT_NEXT(a_load_no_item, clk_i, rst_ni, accept && kind_i == KIND_LOAD, !s1_v_q)
  `MCM_ASSERT_IMPLIES(a_full_stalls, clk_i, rst_ni,
                      out_v_q && out_stall_i && s2_v_q && s1_v_q, in_stall_o)

endmodule
`default_nettype wire

// ===== hw/rtl/mcm_lane.sv =====
`default_nettype none
module mcm_lane import mcm_pkg::*; #(
  parameter int NCOL      = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire pipe_ctrl_t               ctrl_i,
  input  wire logic signed [ELEM_W-1:0] row_i [NCOL],
  input  wire logic signed [ELEM_W-1:0] col_i [LANES],
  output logic signed [ELEM_W-1:0]      prod_o,
  output logic                          clip_o
);

  logic signed [PROD_W-1:0] prod_d [NCOL];
  logic signed [PROD_W-1:0] prod_q [NCOL];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-ELEM_W:0]    upper;
  logic                     fits;

  always_comb begin
    for (int k = 0; k < NCOL; k++) begin
      prod_d[k] = row_i[k] * col_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NCOL; k++) begin
      sum_d = sum_d + SUM_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      sum_q <= sum_d;
    end
  end

  // floor shift, then clip to the 32-bit range
  assign shifted = sum_q >>> FRAC_BITS;
  assign upper   = shifted[SUM_W-1:ELEM_W-1];
  assign fits    = (&upper) | ~(|upper);
  assign clip_o  = ~fits;
  assign prod_o  = fits ? shifted[ELEM_W-1:0] : (sum_q[SUM_W-1] ? SAT_MIN : SAT_MAX);

endmodule
`default_nettype wire
